@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and control types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY    = 16;
	localparam int PRIO_WIDTH  = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_WIDTH   = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_code_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

	typedef struct packed {
		logic rsp_free;
	} spq_sts_t;

endpackage

@@ hdl/spq_ifs.sv @@
// ----------------------------------------------------------------------------
// spq_ifs
// Request, response and configuration channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic [spq_pkg::PRIO_WIDTH-1:0]  priority_req;
	logic [spq_pkg::VALUE_WIDTH-1:0] value;

	modport source (output valid, req_type, priority_req, value, input ready);
	modport sink   (input valid, req_type, priority_req, value, output ready);
endinterface

interface spq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [spq_pkg::PRIO_WIDTH-1:0]  out_priority;
	logic [spq_pkg::VALUE_WIDTH-1:0] out_value;
	logic [spq_pkg::CNT_WIDTH-1:0]   count;
	logic                            is_empty;

	modport source (output valid, ok, out_priority, out_value, count, is_empty,
		input ready);
	modport sink   (input valid, ok, out_priority, out_value, count, is_empty,
		output ready);
endinterface

interface spq_cfg_if;
	logic valid;
	logic ready;
	logic order_descending;

	modport source (output valid, order_descending, input ready);
	modport sink   (input valid, order_descending, output ready);
endinterface

@@ hdl/sorted_priority_queue.sv @@
// An accepted item is held in the request register and, once the response register is free, executed into it.
// The controller alternates idle and execute states, so a new item is taken
//   only after the last one has executed; all slots compare and shift in parallel.
// A stalled response holds the next item in the execute state.
// Reset: count cleared, ascending order; slot contents are left as is.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in shift-register slots; insert,
// remove head and clear, equal priorities served first in, first out.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp,
	spq_cfg_if.sink   cfg
);

	spq_pkg::spq_cmd_t cmd;
	spq_pkg::spq_sts_t sts;

	assign cfg.ready = 1'b1;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid),
		.cfg_order    (cfg.order_descending),
		.req_type     (req.req_type),
		.priority_req (req.priority_req),
		.value        (req.value),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.ok           (rsp.ok),
		.out_priority (rsp.out_priority),
		.out_value    (rsp.out_value),
		.count        (rsp.count),
		.is_empty     (rsp.is_empty)
	);

endmodule

@@ hdl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: takes an item, then runs it through the datapath once the
// response register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  spq_pkg::spq_sts_t sts,
	output spq_pkg::spq_cmd_t cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = spq_pkg::ST_EXEC;
			end
			spq_pkg::ST_EXEC: begin
				if (sts.rsp_free) state_nxt = spq_pkg::ST_IDLE;
			end
			default: state_nxt = spq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			spq_pkg::ST_EXEC: begin
				cmd.exec = sts.rsp_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == spq_pkg::ST_EXEC)
		else $error("accepted item did not move controller to execute");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::ST_EXEC && !sts.rsp_free |=> state_q == spq_pkg::ST_EXEC)
		else $error("item dropped while response register was busy");

	a_exec_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> state_q == spq_pkg::ST_EXEC && sts.rsp_free)
		else $error("execute issued while response register was busy");

endmodule

@@ hdl/spq_dp.sv @@
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: request register, sorted shift-register slots with one
// comparator per slot, order register and response register.
// ----------------------------------------------------------------------------
module spq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spq_pkg::spq_cmd_t               cmd,
	output spq_pkg::spq_sts_t               sts,
	input  logic                            cfg_we,
	input  logic                            cfg_order,
	input  logic [1:0]                      req_type,
	input  logic [spq_pkg::PRIO_WIDTH-1:0]  priority_req,
	input  logic [spq_pkg::VALUE_WIDTH-1:0] value,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic                            ok,
	output logic [spq_pkg::PRIO_WIDTH-1:0]  out_priority,
	output logic [spq_pkg::VALUE_WIDTH-1:0] out_value,
	output logic [spq_pkg::CNT_WIDTH-1:0]   count,
	output logic                            is_empty
);

	localparam int CAP = spq_pkg::CAPACITY;
	localparam int PW  = spq_pkg::PRIO_WIDTH;
	localparam int VW  = spq_pkg::VALUE_WIDTH;
	localparam int CW  = spq_pkg::CNT_WIDTH;

	logic [1:0]    req_type_q;
	logic [PW-1:0] prio_q;
	logic [VW-1:0] value_q;
	logic          order_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] prio_slot_q [CAP];
	logic [VW-1:0] val_slot_q  [CAP];

	logic          rsp_valid_q;
	logic          ok_q;
	logic [PW-1:0] out_prio_q;
	logic [VW-1:0] out_val_q;
	logic [CW-1:0] out_cnt_q;
	logic          empty_q;

	logic [CAP-1:0] goes_first;
	logic [CAP-1:0] seen;
	logic [CAP-1:0] take_new;
	logic [CAP-1:0] shift_in;
	logic           any_first;
	logic           full;
	logic           empty;

	logic          ok_nxt;
	logic [PW-1:0] prio_nxt;
	logic [VW-1:0] val_nxt;
	logic [CW-1:0] cnt_nxt;
	logic          do_insert;
	logic          do_remove;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			prio_q     <= priority_req;
			value_q    <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_order;
		end
	end

	assign full  = (count_q == CW'(CAP));
	assign empty = (count_q == '0);

	// per-slot compare, then first-hit search from the head
	always_comb begin
		logic acc;
		acc = 1'b0;
		for (int i = 0; i < CAP; i++) begin
			goes_first[i] = (CW'(i) < count_q) &&
				(order_q ? (prio_q > prio_slot_q[i]) : (prio_q < prio_slot_q[i]));
			seen[i]       = acc;
			acc           = acc | goes_first[i];
		end
		any_first = acc;
		for (int i = 0; i < CAP; i++) begin
			take_new[i] = (goes_first[i] && !seen[i]) || (!any_first && CW'(i) == count_q);
			shift_in[i] = seen[i] && (CW'(i) <= count_q);
		end
	end

	always_comb begin
		ok_nxt    = 1'b0;
		cnt_nxt   = count_q;
		prio_nxt  = empty ? '0 : prio_slot_q[0];
		val_nxt   = empty ? '0 : val_slot_q[0];
		do_insert = 1'b0;
		do_remove = 1'b0;
		unique case (spq_pkg::req_code_t'(req_type_q))
			spq_pkg::REQ_INSERT: begin
				if (!full) begin
					ok_nxt    = 1'b1;
					do_insert = 1'b1;
					cnt_nxt   = CW'(count_q + 1'b1);
					if (take_new[0]) begin
						prio_nxt = prio_q;
						val_nxt  = value_q;
					end
				end
			end
			spq_pkg::REQ_REMOVE: begin
				if (!empty) begin
					ok_nxt    = 1'b1;
					do_remove = 1'b1;
					cnt_nxt   = CW'(count_q - 1'b1);
				end
			end
			spq_pkg::REQ_CLEAR: begin
				ok_nxt   = 1'b1;
				cnt_nxt  = '0;
				prio_nxt = '0;
				val_nxt  = '0;
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= cnt_nxt;
		end
	end

	for (genvar g = 0; g < CAP; g++) begin : g_slot
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_insert) begin
					if (take_new[g]) begin
						prio_slot_q[g] <= prio_q;
						val_slot_q[g]  <= value_q;
					end else if (shift_in[g]) begin
						if (g > 0) begin
							prio_slot_q[g] <= prio_slot_q[(g > 0) ? g - 1 : 0];
							val_slot_q[g]  <= val_slot_q[(g > 0) ? g - 1 : 0];
						end
					end
				end else if (do_remove) begin
					if (g < CAP - 1) begin
						prio_slot_q[g] <= prio_slot_q[(g < CAP - 1) ? g + 1 : g];
						val_slot_q[g]  <= val_slot_q[(g < CAP - 1) ? g + 1 : g];
					end
				end
			end
		end
	end

	assign sts.rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q       <= ok_nxt;
			out_prio_q <= prio_nxt;
			out_val_q  <= val_nxt;
			out_cnt_q  <= cnt_nxt;
			empty_q    <= (cnt_nxt == '0);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign ok           = ok_q;
	assign out_priority = out_prio_q;
	assign out_value    = out_val_q;
	assign count        = out_cnt_q;
	assign is_empty     = empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("entry count above capacity");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && req_type_q == spq_pkg::REQ_REMOVE && count_q != '0
		|=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not drop one entry");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && req_type_q == spq_pkg::REQ_CLEAR |=> count_q == '0 && empty_q)
		else $error("clear left entries");

endmodule
